// File: hw/rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Request and result types, filter codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 16;
    localparam int CFG_W    = 16;
    localparam int INDEX_W  = 2;

    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [INDEX_W-1:0] REG_HAS_ALPHA    = 2'd2;

    localparam logic [2:0] FILTER_NONE    = 3'd0;
    localparam logic [2:0] FILTER_SUB     = 3'd1;
    localparam logic [2:0] FILTER_UP      = 3'd2;
    localparam logic [2:0] FILTER_AVERAGE = 3'd3;
    localparam logic [2:0] FILTER_PAETH   = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } src_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } pix_t;

endpackage

`default_nettype wire

// File: hw/rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs 8-bit RGB/RGBA scanline bytes (None, Sub, Up, Average, Paeth)
// against a row store holding the previous reconstructed row.
//
// Channel   Direction  Handshake              Payload
// src       in         src_valid/src_ready    src_data  (src_t)
// pix       out        pix_valid/pix_ready    pix_data  (pix_t)
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// One byte per cycle while src_ready is high; the row store read is
// registered, and reconstruction and write-back follow in the next cycle,
// feeding a four-entry result queue that absorbs output stalls.
// Reset clears all control state; the row store needs no clearing pass.
// src_ready drops only when the result queue could overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_ready,
    input  wire src_t               src_data,
    output logic                    pix_valid,
    input  wire logic               pix_ready,
    output pix_t                    pix_data,
    input  wire logic               cfg_we,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    localparam int ROW_STORE  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = $clog2(ROW_STORE);
    localparam int STRIDE_W   = $clog2(ROW_STORE + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        logic [7:0]        pick;
        pa = signed'({2'b00, b}) - signed'({2'b00, c});
        pb = signed'({2'b00, a}) - signed'({2'b00, c});
        pc = signed'({2'b00, a}) + signed'({2'b00, b}) - signed'({1'b0, c, 1'b0});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) pick = a;
        else if (pb <= pc)        pick = b;
        else                      pick = c;
        return pick;
    endfunction

    // configuration
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic                has_alpha_reg;

    // row control
    logic [ADDR_W-1:0]   col_reg,     col_next;
    logic [HEIGHT_W-1:0] row_reg,     row_next;
    logic [2:0]          filter_reg,  filter_next;
    logic                await_reg,   await_next;
    logic                first_reg,   first_next;
    logic                err_reg,     err_next;

    // reconstruction stage
    logic                b_valid_reg, b_valid_next;
    logic [7:0]          b_byte_reg;
    logic [2:0]          b_filter_reg;
    logic [ADDR_W-1:0]   b_col_reg;
    logic                b_first_reg;
    logic                b_row_end_reg;
    logic                b_image_end_reg;
    logic                b_bad_reg;
    logic [7:0]          mem_q_reg;
    logic [31:0]         left_reg;
    logic [31:0]         upper_reg;

    logic [7:0]          row_mem [ROW_STORE];

    // result queue
    pix_t                fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                src_fire;
    logic                pop;
    logic                chans4;
    logic [STRIDE_W-1:0] width_eff;
    logic [STRIDE_W-1:0] stride;
    logic [HEIGHT_W-1:0] height_eff;
    logic                last_col;
    logic                last_row;
    logic                take_bad;
    logic                take_pix;
    logic                await_eff;
    logic                err_eff;
    logic                first_eff;
    logic [ADDR_W-1:0]   col_eff;
    logic [HEIGHT_W-1:0] row_eff;
    logic [2:0]          filter_eff;

    logic                b_col_zero;
    logic [7:0]          a_val;
    logic [7:0]          b_val;
    logic [7:0]          c_val;
    logic [8:0]          avg_sum;
    logic [7:0]          pred;
    logic [7:0]          recon;
    pix_t                b_result;

    assign src_fire = src_valid && src_ready;
    assign pop      = pix_valid && pix_ready;
    assign src_ready = ({1'b0, count_reg} + {{CNT_W{1'b0}}, b_valid_reg})
                       <= (CNT_W + 1)'(FIFO_DEPTH - 1);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_W'(1);
            image_height_reg <= HEIGHT_W'(1);
            has_alpha_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_HAS_ALPHA:    has_alpha_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // row geometry
    always_comb
    begin
        chans4 = has_alpha_reg && (MAX_CHANNELS == 4);
        if (image_width_reg == '0)
            width_eff = STRIDE_W'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            width_eff = STRIDE_W'(MAX_WIDTH);
        else
            width_eff = STRIDE_W'(image_width_reg);
        stride     = chans4 ? (width_eff << 2) : (width_eff + (width_eff << 1));
        height_eff = (image_height_reg == '0) ? HEIGHT_W'(1) : image_height_reg;
    end

    // request control
    always_comb
    begin
        await_eff  = src_data.image_start ? 1'b1 : await_reg;
        err_eff    = src_data.image_start ? 1'b0 : err_reg;
        first_eff  = src_data.image_start ? 1'b1 : first_reg;
        col_eff    = src_data.image_start ? '0 : col_reg;
        row_eff    = src_data.image_start ? '0 : row_reg;
        filter_eff = src_data.image_start ? FILTER_NONE : filter_reg;

        last_col = ({1'b0, col_eff} + (ADDR_W + 1)'(1)) >= (ADDR_W + 1)'(stride);
        last_row = last_col && (({1'b0, row_eff} + (HEIGHT_W + 1)'(1))
                                >= {1'b0, height_eff});

        col_next    = col_reg;
        row_next    = row_reg;
        filter_next = filter_reg;
        await_next  = await_reg;
        first_next  = first_reg;
        err_next    = err_reg;
        take_bad    = 1'b0;
        take_pix    = 1'b0;

        if (src_fire)
        begin
            col_next    = col_eff;
            row_next    = row_eff;
            filter_next = filter_eff;
            await_next  = await_eff;
            first_next  = first_eff;
            err_next    = err_eff;
            if (!err_eff)
            begin
                if (await_eff)
                begin
                    if (src_data.data_byte > {5'b00000, FILTER_PAETH})
                    begin
                        err_next = 1'b1;
                        take_bad = 1'b1;
                    end
                    else
                    begin
                        filter_next = src_data.data_byte[2:0];
                        await_next  = 1'b0;
                        col_next    = '0;
                    end
                end
                else
                begin
                    take_pix = 1'b1;
                    if (last_row)
                    begin
                        col_next    = '0;
                        row_next    = '0;
                        filter_next = FILTER_NONE;
                        await_next  = 1'b1;
                        first_next  = 1'b1;
                        err_next    = 1'b0;
                    end
                    else if (last_col)
                    begin
                        col_next   = '0;
                        row_next   = row_eff + HEIGHT_W'(1);
                        first_next = 1'b0;
                        await_next = 1'b1;
                    end
                    else
                    begin
                        col_next = col_eff + ADDR_W'(1);
                    end
                end
            end
        end
        b_valid_next = take_bad || take_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            filter_reg  <= FILTER_NONE;
            await_reg   <= 1'b1;
            first_reg   <= 1'b1;
            err_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            filter_reg  <= filter_next;
            await_reg   <= await_next;
            first_reg   <= first_next;
            err_reg     <= err_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // hold request fields for reconstruction
    always_ff @(posedge clk)
    begin
        if (src_fire)
        begin
            b_byte_reg      <= src_data.data_byte;
            b_filter_reg    <= filter_eff;
            b_col_reg       <= col_eff;
            b_first_reg     <= first_eff;
            b_row_end_reg   <= last_col;
            b_image_end_reg <= last_row;
            b_bad_reg       <= take_bad;
        end
    end

    // row store
    always_ff @(posedge clk)
    begin
        if (src_fire)
            mem_q_reg <= row_mem[col_eff];
        if (b_valid_reg && !b_bad_reg)
            row_mem[b_col_reg] <= recon;
    end

    // reconstruction
    always_comb
    begin
        b_col_zero = (b_col_reg == '0);
        b_val      = b_first_reg ? 8'd0 : mem_q_reg;
        if (b_col_zero)
        begin
            a_val = 8'd0;
            c_val = 8'd0;
        end
        else if (chans4)
        begin
            a_val = left_reg[31:24];
            c_val = upper_reg[31:24];
        end
        else
        begin
            a_val = left_reg[23:16];
            c_val = upper_reg[23:16];
        end
        avg_sum = {1'b0, a_val} + {1'b0, b_val};
        case (b_filter_reg)
            FILTER_SUB:     pred = a_val;
            FILTER_UP:      pred = b_val;
            FILTER_AVERAGE: pred = avg_sum[8:1];
            FILTER_PAETH:   pred = paeth_pick(a_val, b_val, c_val);
            default:        pred = 8'd0;
        endcase
        recon = b_byte_reg + pred;

        if (b_bad_reg)
        begin
            b_result.pixel_byte = 8'd0;
            b_result.row_end    = 1'b0;
            b_result.image_end  = 1'b0;
            b_result.bad_filter = 1'b1;
        end
        else
        begin
            b_result.pixel_byte = recon;
            b_result.row_end    = b_row_end_reg;
            b_result.image_end  = b_image_end_reg;
            b_result.bad_filter = 1'b0;
        end
    end

    // advance left and upper-left history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            upper_reg <= '0;
        end
        else if (b_valid_reg && !b_bad_reg)
        begin
            left_reg  <= b_col_zero ? {24'd0, recon} : {left_reg[23:0], recon};
            upper_reg <= b_col_zero ? {24'd0, b_val} : {upper_reg[23:0], b_val};
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
            fifo_mem[wr_ptr_reg] <= b_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (b_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (b_valid_reg && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (!b_valid_reg && pop)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign pix_valid = (count_reg != '0);
    assign pix_data  = fifo_mem[rd_ptr_reg];

endmodule

`default_nettype wire
